// ===== rtl/sspq_pkg.sv =====
// sspq_pkg: types and constants shared by the sorted-list priority queue.
// Depends on nothing; every rtl/ file imports it.
package sspq_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned CAPACITY_DEF = 1024;

    localparam logic signed [DATA_W-1:0] EMPTY_TOP = '1;   // -1

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  top_value;
        logic                      empty_res;
        logic [COUNT_W-1:0]        count;
        logic                      overflow;
    } rsp_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ===== rtl/sspq_cell.sv =====
// sspq_cell: one slot of the sorted row; holds one entry and trades it with
// its neighbors on push (shift toward the bottom) or pop (shift toward the top).
// Depends on sspq_pkg.
module sspq_cell
    import sspq_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic                      occupied,
    input  logic signed [DATA_W-1:0]  above_entry,
    input  logic                      above_keep,
    input  logic signed [DATA_W-1:0]  below_entry,
    output logic signed [DATA_W-1:0]  entry,
    output logic                      keep,
    output logic signed [DATA_W-1:0]  entry_next
);

    logic signed [DATA_W-1:0] entry_reg;

    // strictly smaller entries stay put; equal ones move below the new value
    assign keep  = occupied && (entry_reg < ctrl.value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (above_keep)
                entry_next = ctrl.value;
            else
                entry_next = above_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = below_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sspq_obuf.sv =====
// sspq_obuf: result register plus one skid slot between the queue and the
// result channel. Depends on sspq_pkg.
module sspq_obuf
    import sspq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  rsp_t  load_data,
    output logic  full,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic skid_valid_reg;
    rsp_t skid_reg;
    logic drain;

    assign drain     = !rsp_valid_reg || !rsp_stall;
    assign full      = skid_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            rsp_valid_reg  <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
            rsp_reg <= skid_valid_reg ? skid_reg : load_data;
        else if (load)
            skid_reg <= load_data;
    end

`ifndef ASSERT_OFF
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid holds a beat while result register is empty");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !skid_valid_reg)
        else $error("beat loaded while skid slot is occupied");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !rsp_stall) |=> (rsp_valid_reg && rsp_reg == $past(skid_reg)))
        else $error("skid beat not promoted to result register");
`endif

endmodule

// ===== rtl/sorted_stack_priority_queue_top.sv =====
// sorted_stack_priority_queue_top: row of sspq_cell slots kept in ascending
// order (smallest in cell 0), entry counter, and the sspq_obuf result stage.
// Depends on sspq_pkg, sspq_cell, sspq_obuf.
//
//   channel | valid     | stall     | payload        | beat
//   --------+-----------+-----------+----------------+------------------------------
//   request | req_valid | req_stall | req  (req_t)   | push value or pop smallest
//   result  | rsp_valid | rsp_stall | rsp  (rsp_t)   | top, empty, count, overflow
//
// One request per cycle unless req_stall is high; its result is registered in the sspq_obuf stage.
// Each cell compares the broadcast value against its own entry and loads from itself, its
// upper neighbor or the bus (its lower neighbor on a pop) in the same cycle: that compare sets the clock.
// Reset clears the count and the result stage; cell contents are left as they are.
// req_stall rises only when the result register and its skid slot both hold beats.
module sorted_stack_priority_queue_top
    import sspq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             push_ok;
    logic             pop_ok;
    logic             ovf;
    cell_ctrl_t       ctrl;
    rsp_t             result;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    logic signed [DATA_W-1:0] entry      [CAPACITY];
    logic signed [DATA_W-1:0] entry_next [CAPACITY];
    logic                     keep       [CAPACITY];

    assign accept   = req_valid && !req_stall;
    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign push_ok  = accept && (req.op == OP_PUSH) && !is_full;
    assign pop_ok   = accept && (req.op == OP_POP) && !is_empty;
    assign ovf      = accept && (req.op == OP_PUSH) && is_full;

    assign ctrl.push  = push_ok;
    assign ctrl.pop   = pop_ok;
    assign ctrl.value = req.value;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
            count_next = count_reg + 1'b1;
        else if (pop_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] above_entry;
            logic                     above_keep;
            logic signed [DATA_W-1:0] below_entry;
            logic                     occupied;

            // cell 0 sees an always-smaller sentinel above it
            if (i == 0)
            begin : g_first
                assign above_entry = '0;
                assign above_keep  = 1'b1;
            end
            else
            begin : g_mid
                assign above_entry = entry[i-1];
                assign above_keep  = keep[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign below_entry = '0;
            end
            else
            begin : g_notlast
                assign below_entry = entry[i+1];
            end

            assign occupied = (CNT_W'(i) < count_reg);

            sspq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied),
                .above_entry (above_entry),
                .above_keep  (above_keep),
                .below_entry (below_entry),
                .entry       (entry[i]),
                .keep        (keep[i]),
                .entry_next  (entry_next[i])
            );
        end
    endgenerate

    assign count_wide       = {{COUNT_W{1'b0}}, count_next};
    assign result.top_value = (count_next == '0) ? EMPTY_TOP : entry_next[0];
    assign result.empty_res = (count_next == '0);
    assign result.count     = count_wide[COUNT_W-1:0];
    assign result.overflow  = ovf;

    sspq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .full      (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_full_push_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_PUSH && is_full) |=> (count_reg == CNT_FULL))
        else $error("push into full queue changed the count");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not remove one entry");

    a_top_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > CNT_W'(1)) |-> (entry[0] <= entry[1]))
        else $error("top entry larger than its neighbor");
`endif

endmodule
